@@ hdl/shp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_pkg - shared types and constants for the 3x3 sharpening filter
// Sizes, register indexes, pixel and window types, struct bundles.
// ----------------------------------------------------------------------------
package shp_pkg;

   localparam int MAX_WIDTH     = 4096;
   localparam int MAX_HEIGHT    = 4096;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
   localparam int SIZE_BITS     = 13;
   localparam int WGT_BITS      = 6;
   localparam int CHAN_BITS     = 8;
   localparam int PIX_BITS      = 3 * CHAN_BITS;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 13;

   // result queue
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SIZE_BITS-1:0] SIZE_RESET    = 13'd1;
   localparam logic [WGT_BITS-1:0]  CENTER_RESET  = 6'd5;
   localparam logic [WGT_BITS-1:0]  EDGE_RESET    = 6'h3F;
   localparam logic [WGT_BITS-1:0]  CORNER_RESET  = 6'd0;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_IMAGE_WIDTH   = 3'd0,
      CSR_IMAGE_HEIGHT  = 3'd1,
      CSR_CENTER_WEIGHT = 3'd2,
      CSR_EDGE_WEIGHT   = 3'd3,
      CSR_CORNER_WEIGHT = 3'd4
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   // pixel packed as {blue, green, red}
   typedef logic [PIX_BITS-1:0] pix_type;
   // window[row][col], row 0 on top, col 0 on the left
   typedef pix_type [2:0][2:0] win_type;

   typedef struct packed {
      pix_type older;
      pix_type newer;
   } lcol_type;

   typedef struct packed {
      logic [WGT_BITS-1:0] center_w;
      logic [WGT_BITS-1:0] edge_w;
      logic [WGT_BITS-1:0] corner_w;
   } kern_type;

   typedef struct packed {
      logic                en;
      logic                older_en;
      logic [COL_BITS-1:0] addr;
      pix_type             older;
      pix_type             newer;
   } line_wr_type;

   typedef struct packed {
      logic                 eoi;
      logic                 last;
      logic [CHAN_BITS-1:0] blue;
      logic [CHAN_BITS-1:0] green;
      logic [CHAN_BITS-1:0] red;
   } rsp_type;

   typedef struct packed {
      logic first;
      logic second;
   } push_type;

endpackage

@@ hdl/sharpen_3x3_convolution.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sharpen_3x3_convolution - 3x3 sharpening filter on an RGB raster stream
// Replicated borders, per-channel clamp to 0..255, programmable kernel.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request per pixel in raster order (tuser = 0) or a
//   drain request (tuser = 1). Rows of results trail the input by one row;
//   after the last pixel, send one drain request per column to flush the
//   bottom row. The last drain result carries rsp_tuser (end of image).
//   rsp_tlast marks the final result caused by a request.
//   csr_* writes image width, height and the center/edge/corner weights;
//   write them only while no results are pending.
// Pipeline: an accepted request goes through the line read, the window
//   build and the lane math into the queue that drives rsp_tvalid.
// Throughput: one request per cycle. A row-end pixel gives two results,
//   which the 8-entry response queue absorbs; req_tready drops only when
//   the queue plus results still in the pipe could overflow it.
// Stall: with rsp_tready low the queue fills and req_tready falls; nothing
//   is lost. Reset clears the counters, the pipe and the queue; line
//   buffers keep their contents and need no clearing pass.
// ----------------------------------------------------------------------------
module sharpen_3x3_convolution (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,  // red, green, blue
   input  logic                              req_tuser,  // opcode
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,  // red, green, blue
   output logic                              rsp_tlast,  // last_in_run
   output logic                              rsp_tuser,  // end_of_image
   // configuration
   input  logic                              csr_we,
   input  logic [shp_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [shp_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int CB = shp_pkg::COL_BITS;
   localparam int RB = shp_pkg::ROW_BITS;
   localparam int CW = shp_pkg::CHAN_BITS;

   // ---------------- configuration registers ----------------
   logic [shp_pkg::SIZE_BITS-1:0] width_ff, height_ff;
   logic [shp_pkg::WGT_BITS-1:0]  cw_ff, ew_ff, kw_ff;
   shp_pkg::kern_type             kern;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= shp_pkg::SIZE_RESET;
         height_ff <= shp_pkg::SIZE_RESET;
         cw_ff     <= shp_pkg::CENTER_RESET;
         ew_ff     <= shp_pkg::EDGE_RESET;
         kw_ff     <= shp_pkg::CORNER_RESET;
      end else if (csr_we) begin
         unique case (shp_pkg::csr_index_type'(csr_addr))
            shp_pkg::CSR_IMAGE_WIDTH:   width_ff  <= csr_wdata;
            shp_pkg::CSR_IMAGE_HEIGHT:  height_ff <= csr_wdata;
            shp_pkg::CSR_CENTER_WEIGHT: cw_ff     <= csr_wdata[shp_pkg::WGT_BITS-1:0];
            shp_pkg::CSR_EDGE_WEIGHT:   ew_ff     <= csr_wdata[shp_pkg::WGT_BITS-1:0];
            shp_pkg::CSR_CORNER_WEIGHT: kw_ff     <= csr_wdata[shp_pkg::WGT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign kern = '{center_w: cw_ff, edge_w: ew_ff, corner_w: kw_ff};

   // last column / last row, sizes saturated to 1..MAX
   logic [CB-1:0] last_col;
   logic [RB-1:0] last_row;

   always_comb begin
      if (width_ff == '0) begin
         last_col = '0;
      end else if (width_ff >= shp_pkg::SIZE_BITS'(shp_pkg::MAX_WIDTH)) begin
         last_col = CB'(shp_pkg::MAX_WIDTH - 1);
      end else begin
         last_col = CB'(width_ff - shp_pkg::SIZE_BITS'(1));
      end
      if (height_ff == '0) begin
         last_row = '0;
      end else if (height_ff >= shp_pkg::SIZE_BITS'(shp_pkg::MAX_HEIGHT)) begin
         last_row = RB'(shp_pkg::MAX_HEIGHT - 1);
      end else begin
         last_row = RB'(height_ff - shp_pkg::SIZE_BITS'(1));
      end
   end

   // ---------------- stage 0: accept, position, line read ----------------
   logic          acc;
   logic          is_drain;
   logic          take;          // request does work (not ignored)
   logic          row_end;
   logic          drain_end;
   logic [CB-1:0] rd_addr;

   logic [CB-1:0] col_ff, col_in;
   logic [RB-1:0] row_ff, row_in;
   logic [CB-1:0] dcol_ff, dcol_in;
   logic          done_ff, done_in;   // all pixels in, drain expected

   shp_pkg::pix_type px_in;

   assign acc      = req_tvalid & req_tready;
   assign is_drain = (shp_pkg::op_type'(req_tuser) == shp_pkg::OP_DRAIN);
   assign take     = acc & (is_drain ? done_ff : ~done_ff);
   assign row_end  = (col_ff >= last_col);
   assign drain_end = (dcol_ff >= last_col);
   assign rd_addr  = is_drain ? (dcol_ff + CB'(1)) : col_ff;
   assign px_in    = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      dcol_in = dcol_ff;
      done_in = done_ff;
      if (take) begin
         if (is_drain) begin
            if (drain_end) begin
               done_in = 1'b0;
               row_in  = '0;
               col_in  = '0;
               dcol_in = '0;
            end else begin
               dcol_in = dcol_ff + CB'(1);
            end
         end else if (row_end) begin
            col_in = '0;
            if (row_ff >= last_row) begin
               done_in = 1'b1;
               dcol_in = '0;
            end else begin
               row_in = row_ff + RB'(1);
            end
         end else begin
            col_in = col_ff + CB'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         dcol_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         dcol_ff <= dcol_in;
         done_ff <= done_in;
      end
   end

   // stage 1 request info
   logic             s1_v_ff;
   shp_pkg::op_type  s1_op_ff;
   shp_pkg::pix_type s1_px_ff;
   logic [CB-1:0]    s1_addr_ff;
   logic             s1_col0_ff, s1_row0_ff, s1_row1_ff, s1_row_end_ff;
   logic             s1_eoi_ff, s1_h1_ff, s1_d0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= take;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff      <= shp_pkg::op_type'(req_tuser);
      s1_px_ff      <= px_in;
      s1_addr_ff    <= col_ff;
      s1_col0_ff    <= (col_ff == '0);
      s1_row0_ff    <= (row_ff == '0);
      s1_row1_ff    <= (row_ff == RB'(1));
      s1_row_end_ff <= row_end;
      s1_eoi_ff     <= drain_end;
      s1_h1_ff      <= (last_row == '0);
      s1_d0_ff      <= (dcol_ff == '0);
   end

   // ---------------- line buffers ----------------
   shp_pkg::line_wr_type lwr;
   shp_pkg::pix_type     rd_older, rd_newer;

   shp_line_store u_lines (
      .clock    (clock),
      .rd_en    (acc),
      .rd_addr  (rd_addr),
      .wr       (lwr),
      .rd_older (rd_older),
      .rd_newer (rd_newer)
   );

   // ---------------- stage 1: window build ----------------
   logic             s1_pix;
   logic             s1_drn;
   logic             fwd_v_ff, fwd_v_in;
   shp_pkg::pix_type fwd_older_ff, fwd_newer_ff;
   shp_pkg::pix_type older_q, newer_q;
   shp_pkg::pix_type top, mid, older_kept;

   assign s1_pix = s1_v_ff & (s1_op_ff == shp_pkg::OP_PIXEL);
   assign s1_drn = s1_v_ff & (s1_op_ff == shp_pkg::OP_DRAIN);

   // bypass of a column written on the same edge it was read
   assign older_q    = fwd_v_ff ? fwd_older_ff : rd_older;
   assign newer_q    = fwd_v_ff ? fwd_newer_ff : rd_newer;
   assign mid        = newer_q;
   assign top        = s1_row1_ff ? mid : older_q;
   assign older_kept = s1_row0_ff ? older_q : mid;

   always_comb begin
      lwr.en       = s1_pix;
      lwr.older_en = ~s1_row0_ff;
      lwr.addr     = s1_addr_ff;
      lwr.older    = mid;
      lwr.newer    = s1_px_ff;
   end

   assign fwd_v_in = acc & s1_pix & (rd_addr == s1_addr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_v_ff <= 1'b0;
      end else begin
         fwd_v_ff <= fwd_v_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_older_ff <= older_kept;
      fwd_newer_ff <= s1_px_ff;
   end

   // pixel window and drain columns
   shp_pkg::win_type  win_ff, win_in;
   shp_pkg::lcol_type dr_prev_ff, dr_prev_in;
   shp_pkg::lcol_type dr_cur_ff, dr_cur_in;
   shp_pkg::lcol_type dcol_l, dcol_r;
   shp_pkg::lcol_type dcols [3];
   shp_pkg::win_type  dwin;

   always_comb begin
      win_in = win_ff;
      if (s1_pix) begin
         if (s1_col0_ff) begin
            for (int i = 0; i < 3; i++) begin
               win_in[0][i] = top;
               win_in[1][i] = mid;
               win_in[2][i] = s1_px_ff;
            end
         end else begin
            for (int r = 0; r < 3; r++) begin
               win_in[r][0] = win_ff[r][1];
               win_in[r][1] = win_ff[r][2];
            end
            win_in[0][2] = top;
            win_in[1][2] = mid;
            win_in[2][2] = s1_px_ff;
         end
      end
   end

   always_comb begin
      dcol_l   = s1_d0_ff ? dr_cur_ff : dr_prev_ff;
      dcol_r   = s1_eoi_ff ? dr_cur_ff : '{older: older_q, newer: newer_q};
      dcols[0] = dcol_l;
      dcols[1] = dr_cur_ff;
      dcols[2] = dcol_r;
      for (int i = 0; i < 3; i++) begin
         dwin[0][i] = s1_h1_ff ? dcols[i].newer : dcols[i].older;
         dwin[1][i] = dcols[i].newer;
         dwin[2][i] = dcols[i].newer;
      end
      dr_prev_in = dr_prev_ff;
      dr_cur_in  = dr_cur_ff;
      if (s1_drn) begin
         dr_prev_in = dr_cur_ff;
         dr_cur_in  = dcol_r;
      end else if (s1_pix && s1_col0_ff) begin
         // column 0 as stored by this row; first drain starts from it
         dr_cur_in = '{older: older_kept, newer: s1_px_ff};
      end
   end

   always_ff @(posedge clock) begin
      win_ff     <= win_in;
      dr_prev_ff <= dr_prev_in;
      dr_cur_ff  <= dr_cur_in;
   end

   // ---------------- stage 2: lanes ----------------
   logic             s2_v0_ff, s2_v0_in;
   logic             s2_v1_ff, s2_v1_in;
   logic             s2_last0_ff, s2_eoi0_ff, s2_col0_ff;
   shp_pkg::win_type s2_win_ff;

   assign s2_v0_in = s1_drn | (s1_pix & ~s1_row0_ff & ~s1_col0_ff);
   assign s2_v1_in = s1_pix & ~s1_row0_ff & s1_row_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v0_ff <= 1'b0;
         s2_v1_ff <= 1'b0;
      end else begin
         s2_v0_ff <= s2_v0_in;
         s2_v1_ff <= s2_v1_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_last0_ff <= s1_drn | ~s1_row_end_ff;
      s2_eoi0_ff  <= s1_drn & s1_eoi_ff;
      s2_col0_ff  <= s1_col0_ff;
      s2_win_ff   <= s1_drn ? dwin : win_in;
   end

   // window a: as held; window b: right border replicated at row end
   shp_pkg::win_type win_sel [2];

   always_comb begin
      win_sel[0] = s2_win_ff;
      win_sel[1] = s2_win_ff;
      if (!s2_col0_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_sel[1][r][0] = s2_win_ff[r][1];
            win_sel[1][r][1] = s2_win_ff[r][2];
            win_sel[1][r][2] = s2_win_ff[r][2];
         end
      end
   end

   logic [CW-1:0] lane_res [2][3];

   for (genvar gw = 0; gw < 2; gw++) begin : g_win
      for (genvar gc = 0; gc < 3; gc++) begin : g_chan
         localparam int HI = shp_pkg::PIX_BITS - 1 - CW * gc;
         shp_lane u_lane (
            .center  (win_sel[gw][1][1][HI -: CW]),
            .edges   ({win_sel[gw][0][1][HI -: CW], win_sel[gw][2][1][HI -: CW],
                       win_sel[gw][1][0][HI -: CW], win_sel[gw][1][2][HI -: CW]}),
            .corners ({win_sel[gw][0][0][HI -: CW], win_sel[gw][0][2][HI -: CW],
                       win_sel[gw][2][0][HI -: CW], win_sel[gw][2][2][HI -: CW]}),
            .kern    (kern),
            .result  (lane_res[gw][gc])
         );
      end
   end

   // ---------------- merge into response queue ----------------
   shp_pkg::push_type             push;
   shp_pkg::rsp_type              ent_a, ent_b, head;
   logic                          q_not_empty;
   logic                          pop;
   logic [shp_pkg::QCNT_BITS-1:0] q_count;
   logic [shp_pkg::QCNT_BITS:0]   pending;

   always_comb begin
      push.first  = s2_v0_ff;
      push.second = s2_v1_ff;
      ent_a = '{eoi: s2_eoi0_ff, last: s2_last0_ff, blue: lane_res[0][2],
                green: lane_res[0][1], red: lane_res[0][0]};
      ent_b = '{eoi: 1'b0, last: 1'b1, blue: lane_res[1][2],
                green: lane_res[1][1], red: lane_res[1][0]};
   end

   shp_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .ent_a     (ent_a),
      .ent_b     (ent_b),
      .pop       (pop),
      .head      (head),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   // room for two results from each request still in the pipe and the next
   assign pending = {1'b0, q_count}
                  + (shp_pkg::QCNT_BITS + 1)'({s1_v_ff, 1'b0})
                  + (shp_pkg::QCNT_BITS + 1)'({s2_v0_ff | s2_v1_ff, 1'b0});
   assign req_tready = (pending <= (shp_pkg::QCNT_BITS + 1)'(shp_pkg::QUEUE_DEPTH - 2));

   assign pop        = rsp_tvalid & rsp_tready;
   assign rsp_tvalid = q_not_empty;
   assign rsp_tdata  = {head.blue, head.green, head.red};
   assign rsp_tlast  = head.last;
   assign rsp_tuser  = head.eoi;

endmodule

@@ hdl/shp_line_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_line_store - two line buffers (older row, newer row)
// One write port and one registered read port, same column for both rows.
// ----------------------------------------------------------------------------
module shp_line_store (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [shp_pkg::COL_BITS-1:0] rd_addr,
   input  shp_pkg::line_wr_type         wr,
   output shp_pkg::pix_type             rd_older,
   output shp_pkg::pix_type             rd_newer
);

   shp_pkg::pix_type older_mem [shp_pkg::MAX_WIDTH];
   shp_pkg::pix_type newer_mem [shp_pkg::MAX_WIDTH];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         newer_mem[wr.addr] <= wr.newer;
         if (wr.older_en) begin
            older_mem[wr.addr] <= wr.older;
         end
      end
   end

   // read-first: a write to the same column this cycle is bypassed outside
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_older <= older_mem[rd_addr];
         rd_newer <= newer_mem[rd_addr];
      end
   end

endmodule

@@ hdl/shp_lane.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_lane - one color channel of one 3x3 window
// Weighted sum of center, edge and corner taps, clamped to 0..255.
// ----------------------------------------------------------------------------
module shp_lane (
   input  logic [shp_pkg::CHAN_BITS-1:0]       center,
   input  logic [3:0][shp_pkg::CHAN_BITS-1:0]  edges,
   input  logic [3:0][shp_pkg::CHAN_BITS-1:0]  corners,
   input  shp_pkg::kern_type                   kern,
   output logic [shp_pkg::CHAN_BITS-1:0]       result
);

   logic [9:0]         edge_sum;
   logic [9:0]         corner_sum;
   logic signed [18:0] prod_c;
   logic signed [18:0] prod_e;
   logic signed [18:0] prod_k;
   logic signed [18:0] total;

   always_comb begin
      edge_sum   = 10'(edges[0]) + 10'(edges[1]) + 10'(edges[2]) + 10'(edges[3]);
      corner_sum = 10'(corners[0]) + 10'(corners[1]) + 10'(corners[2])
                 + 10'(corners[3]);
      prod_c = $signed(kern.center_w) * $signed({1'b0, center});
      prod_e = $signed(kern.edge_w) * $signed({1'b0, edge_sum});
      prod_k = $signed(kern.corner_w) * $signed({1'b0, corner_sum});
      total  = prod_c + prod_e + prod_k;
      if (total < 19'sd0) begin
         result = '0;
      end else if (total > 19'sd255) begin
         result = '1;
      end else begin
         result = total[shp_pkg::CHAN_BITS-1:0];
      end
   end

endmodule

@@ hdl/shp_out_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shp_out_queue - merge of lane results into the response queue
// Takes up to two results a cycle in order, hands out one per cycle on pop.
// ----------------------------------------------------------------------------
module shp_out_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  shp_pkg::push_type             push,
   input  shp_pkg::rsp_type              ent_a,
   input  shp_pkg::rsp_type              ent_b,
   input  logic                          pop,
   output shp_pkg::rsp_type              head,
   output logic                          not_empty,
   output logic [shp_pkg::QCNT_BITS-1:0] count
);

   shp_pkg::rsp_type               q_ff [shp_pkg::QUEUE_DEPTH];
   logic [shp_pkg::QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [shp_pkg::QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [shp_pkg::QCNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [shp_pkg::QPTR_BITS-1:0]  wr_next;
   logic                           wr_one;
   logic                           wr_two;
   shp_pkg::rsp_type               first_ent;

   always_comb begin
      wr_one    = push.first | push.second;
      wr_two    = push.first & push.second;
      first_ent = push.first ? ent_a : ent_b;
      wr_next   = wr_ptr_ff + shp_pkg::QPTR_BITS'(1);
      wr_ptr_in = wr_ptr_ff + shp_pkg::QPTR_BITS'(wr_one) + shp_pkg::QPTR_BITS'(wr_two);
      rd_ptr_in = rd_ptr_ff + shp_pkg::QPTR_BITS'(pop);
      cnt_in    = cnt_ff + shp_pkg::QCNT_BITS'(wr_one) + shp_pkg::QCNT_BITS'(wr_two)
                - shp_pkg::QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_one) begin
         q_ff[wr_ptr_ff] <= first_ent;
      end
      if (wr_two) begin
         q_ff[wr_next] <= ent_b;
      end
   end

   assign head      = q_ff[rd_ptr_ff];
   assign not_empty = (cnt_ff != '0);
   assign count     = cnt_ff;

endmodule
